>>> src/dlp_pkg.sv
// Shared constants, codes and types for the DDA line pixel generator.
`timescale 1ns / 1ps

package dlp_pkg;

    // Screen geometry and fixed-point format.
    localparam int SCREEN_WIDTH  = 320;
    localparam int FRACTION_BITS = 8;

    // Field widths.
    localparam int COORD_W = 9;
    localparam int ROW_W   = 8;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 16;

    // Minor accumulator and step widths.
    localparam int ACC_W      = COORD_W + FRACTION_BITS;
    localparam int STEP_MAG_W = FRACTION_BITS + 1;
    localparam int STEP_W     = FRACTION_BITS + 2;

    // Divider geometry: dividend is the minor delta scaled by the fraction.
    localparam int DIVIDEND_W = ACC_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    // Command codes carried on the mode field.
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } seq_state_t;

endpackage

>>> src/dlp_divider.sv
// Iterative restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module dlp_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dlp_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [dlp_pkg::COORD_W-1:0]    divisor,
    output logic                           done,
    output logic [dlp_pkg::DIVIDEND_W-1:0] quotient
);
    import dlp_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_COUNT = DIV_CNT_W'(DIVIDEND_W - 1);

    logic                  run_reg;
    logic                  run_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIV_CNT_W-1:0]  count_reg;
    logic [DIV_CNT_W-1:0]  count_next;
    logic [COORD_W-1:0]    rem_reg;
    logic [COORD_W-1:0]    rem_next;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVIDEND_W-1:0] quot_next;
    logic [COORD_W-1:0]    divisor_reg;
    logic [COORD_W-1:0]    divisor_next;
    logic [COORD_W:0]      trial;
    logic [COORD_W:0]      diff;
    logic                  fits;

    // One restoring step: bring in the next dividend bit and try a subtract.
    always_comb
    begin
        trial = {rem_reg, quot_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = (trial >= {1'b0, divisor_reg});
    end

    // Iteration control and datapath update.
    always_comb
    begin
        run_next     = run_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            run_next     = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            quot_next    = dividend;
            divisor_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next  = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            quot_next = {quot_reg[DIVIDEND_W-2:0], fits};
            if (count_reg == LAST_COUNT)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Control state is reset; the datapath registers are loaded on start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    // A finished division leaves a remainder below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < divisor_reg) || (divisor_reg == '0))
        else $error("divider remainder not below divisor");

    // The done pulse lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    // The unit is never running and done at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && run_reg))
        else $error("divider done while still running");

endmodule

>>> src/dda_line_pixel_generator.sv
// Top level of the DDA line pixel generator: sequencer, line state and pixel output register.
`timescale 1ns / 1ps
//
// Usage: the command channel (cmd_valid, cmd_stall) carries one item per command.
// An item with mode = start loads two endpoints and a color and gives no pixel.
// An item with mode = step gives one pixel on the pixel channel (pix_valid,
// pix_stall): its frame buffer address, its color and a last flag that marks
// the final pixel of the line. A step item with no active line gives nothing.
// Timing: a start item keeps cmd_stall high after it is taken until the
// bit-serial divider that forms the minor step has finished (17 quotient bits,
// one per cycle). The pixel of a step item appears on the pixel channel in the
// next cycle. During a line one step item and one pixel pass per cycle while
// the pixel channel does not stall.
// A stalled pixel holds in the output register; a further command is taken only
// in a cycle in which that register is free or being emptied.
// Reset clears the line state: no line is active and no pixel is pending.
//
module dda_line_pixel_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic                        mode,
    input  logic [dlp_pkg::COORD_W-1:0] x_start,
    input  logic [dlp_pkg::ROW_W-1:0]   y_start,
    input  logic [dlp_pkg::COORD_W-1:0] x_end,
    input  logic [dlp_pkg::ROW_W-1:0]   y_end,
    input  logic [dlp_pkg::COLOR_W-1:0] line_color,
    output logic                        pix_valid,
    input  logic                        pix_stall,
    output logic [dlp_pkg::ADDR_W-1:0]  pixel_address,
    output logic [dlp_pkg::COLOR_W-1:0] pixel_color,
    output logic                        last_pixel
);
    import dlp_pkg::*;

    localparam logic [DIVIDEND_W-1:0] MAX_STEP = DIVIDEND_W'(1 << FRACTION_BITS);

    seq_state_t state_reg;
    seq_state_t state_next;

    // Line state.
    logic [ACC_W-1:0]   minor_accum_reg;
    logic [STEP_W-1:0]  minor_step_reg;
    logic [COORD_W-1:0] major_pos_reg;
    logic [COORD_W-1:0] pixels_left_reg;
    logic               x_is_major_reg;
    logic [COLOR_W-1:0] held_color_reg;
    logic               line_active_reg;
    logic               step_neg_reg;
    logic               len_zero_reg;

    // Pixel output register.
    logic               pix_valid_reg;
    logic [ADDR_W-1:0]  pix_addr_reg;
    logic [COLOR_W-1:0] pix_color_reg;
    logic               pix_last_reg;

    // Handshake and decode.
    logic accept;
    logic start_accept;
    logic step_accept;
    logic div_start;
    logic div_done;
    logic [DIVIDEND_W-1:0] div_quotient;

    // Endpoint ordering.
    logic [COORD_W-1:0] ya_ext;
    logic [COORD_W-1:0] yb_ext;
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    logic               x_major;
    logic [COORD_W-1:0] maj_a;
    logic [COORD_W-1:0] maj_b;
    logic [COORD_W-1:0] min_a;
    logic [COORD_W-1:0] min_b;
    logic [COORD_W-1:0] maj0;
    logic [COORD_W-1:0] min0;
    logic [COORD_W-1:0] min1;
    logic [COORD_W-1:0] len;
    logic [COORD_W-1:0] mag;

    // Pixel address and step.
    logic [COORD_W-1:0] minor_pos;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [ADDR_W-1:0]  addr;
    logic [STEP_W-1:0]  q_ext;
    logic [STEP_W-1:0]  step_value;

    assign accept       = cmd_valid && !cmd_stall;
    assign start_accept = accept && (mode == MODE_START);
    assign step_accept  = accept && (mode == MODE_STEP) && line_active_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_accept)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_stall = 1'b1;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = pix_valid_reg && pix_stall;
                div_start = start_accept;
            end
            ST_DIVIDE:
            begin
                cmd_stall = 1'b1;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Pick the major axis and order the endpoints so the major coordinate rises.
    always_comb
    begin
        ya_ext  = COORD_W'(y_start);
        yb_ext  = COORD_W'(y_end);
        adx     = (x_start > x_end) ? (x_start - x_end) : (x_end - x_start);
        ady     = (ya_ext > yb_ext) ? (ya_ext - yb_ext) : (yb_ext - ya_ext);
        x_major = (adx > ady);
        maj_a   = x_major ? x_start : ya_ext;
        maj_b   = x_major ? x_end   : yb_ext;
        min_a   = x_major ? ya_ext  : x_start;
        min_b   = x_major ? yb_ext  : x_end;
        if (maj_a > maj_b)
        begin
            maj0 = maj_b;
            min0 = min_b;
            min1 = min_a;
            len  = maj_a - maj_b;
        end
        else
        begin
            maj0 = maj_a;
            min0 = min_a;
            min1 = min_b;
            len  = maj_b - maj_a;
        end
        mag = (min1 > min0) ? (min1 - min0) : (min0 - min1);
    end

    // The divider forms the step magnitude from the scaled minor delta.
    dlp_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({mag, {FRACTION_BITS{1'b0}}}),
        .divisor  (len),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Signed step from the quotient; a zero-length line steps by zero.
    always_comb
    begin
        q_ext = STEP_W'(div_quotient[STEP_MAG_W-1:0]);
        if (len_zero_reg)
        begin
            step_value = '0;
        end
        else if (step_neg_reg)
        begin
            step_value = '0 - q_ext;
        end
        else
        begin
            step_value = q_ext;
        end
    end

    // Frame buffer address of the current pixel.
    always_comb
    begin
        minor_pos = minor_accum_reg[ACC_W-1:FRACTION_BITS];
        px        = x_is_major_reg ? major_pos_reg : minor_pos;
        py        = x_is_major_reg ? minor_pos : major_pos_reg;
        addr      = ADDR_W'(px) + ADDR_W'(py) * ADDR_W'(SCREEN_WIDTH);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            line_active_reg <= 1'b0;
            pix_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start_accept)
            begin
                line_active_reg <= 1'b1;
            end
            else if (step_accept && (pixels_left_reg == '0))
            begin
                line_active_reg <= 1'b0;
            end
            if (step_accept)
            begin
                pix_valid_reg <= 1'b1;
            end
            else if (!pix_stall)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minor_accum_reg <= '0;
            minor_step_reg  <= '0;
            major_pos_reg   <= '0;
            pixels_left_reg <= '0;
            x_is_major_reg  <= 1'b0;
            held_color_reg  <= '0;
            step_neg_reg    <= 1'b0;
            len_zero_reg    <= 1'b0;
        end
        else if (start_accept)
        begin
            minor_accum_reg <= {min0, {FRACTION_BITS{1'b0}}};
            minor_step_reg  <= '0;
            major_pos_reg   <= maj0;
            pixels_left_reg <= len;
            x_is_major_reg  <= x_major;
            held_color_reg  <= line_color;
            step_neg_reg    <= (min1 < min0);
            len_zero_reg    <= (len == '0);
        end
        else if (div_done)
        begin
            minor_step_reg <= step_value;
        end
        else if (step_accept && (pixels_left_reg != '0))
        begin
            pixels_left_reg <= pixels_left_reg - 1'b1;
            major_pos_reg   <= major_pos_reg + 1'b1;
            minor_accum_reg <= minor_accum_reg
                + {{(ACC_W - STEP_W){minor_step_reg[STEP_W-1]}}, minor_step_reg};
        end
    end

    // Pixel payload loads with each step.
    always_ff @(posedge clk)
    begin
        if (step_accept)
        begin
            pix_addr_reg  <= addr;
            pix_color_reg <= held_color_reg;
            pix_last_reg  <= (pixels_left_reg == '0);
        end
    end

    assign pix_valid     = pix_valid_reg;
    assign pixel_address = pix_addr_reg;
    assign pixel_color   = pix_color_reg;
    assign last_pixel    = pix_last_reg;

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    // The step magnitude never exceeds one whole minor unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_done && !len_zero_reg) |-> (div_quotient <= MAX_STEP))
        else $error("minor step larger than one pixel");

    // A step on an active line always yields a pending pixel next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_accept |=> pix_valid_reg)
        else $error("accepted step produced no pixel");

    // The final pixel of a line ends the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_accept && (pixels_left_reg == '0)) |=> !line_active_reg)
        else $error("line still active after its last pixel");

endmodule
